// File: hw/rtl/grouped_combination_enumerator_macros.svh
// assertion macros for the grouped combination enumerator
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef GROUPED_COMBINATION_ENUMERATOR_MACROS_SVH
`define GROUPED_COMBINATION_ENUMERATOR_MACROS_SVH

// same-cycle implication, disabled while in reset
`define GCE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define GCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/gce_pkg.sv
// shared types, constants and helper functions of the grouped combination enumerator
// no dependencies
package gce_pkg;

    localparam int MAX_SLOTS     = 4;
    localparam int MAX_POOL_SIZE = 16;
    localparam int NUM_POOLS     = 4;

    // slots that the pool map and the selection field can name
    localparam int MAP_SLOTS = 4;

    localparam int SLOT_W      = $clog2(MAX_SLOTS);
    localparam int SCNT_W      = $clog2(MAX_SLOTS + 1);
    localparam int IDX_W       = $clog2(MAX_POOL_SIZE);
    localparam int NIDX_W      = IDX_W + 1;
    localparam int TABLE_DEPTH = NUM_POOLS * MAX_POOL_SIZE;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    localparam int OP_W       = 2;
    localparam int POOL_W     = 2;
    localparam int MEMBER_W   = 4;
    localparam int DEG_W      = 16;
    localparam int RES_W      = 7;
    localparam int SEL_W      = 16;
    localparam int TOT_W      = 18;
    localparam int CNT_CFG_W  = 3;
    localparam int MAP_W      = 8;
    localparam int SIZES_W    = 20;
    localparam int PSZ_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [RES_W-1:0] LMAX_RST = 7'd32;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_RESTART = 2'd1,
        OP_ADVANCE = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOT_COUNT = 2'd0,
        CFG_POOL_MAP   = 2'd1,
        CFG_POOL_SIZES = 2'd2,
        CFG_LMAX       = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RESTART,
        ST_SEARCH,
        ST_EMIT_RD,
        ST_EMIT_ACC,
        ST_DELIVER
    } t_state;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_CLEAR,
        SC_START_STEP,
        SC_TRY
    } t_slot_cmd;

    typedef struct packed {
        logic [SCNT_W-1:0]  count;
        logic [MAP_W-1:0]   pool_map;
        logic [SIZES_W-1:0] pool_sizes;
    } t_cfg;

    typedef struct packed {
        logic restart_ok;
        logic any_unset;
        logic success;
        logic fail;
    } t_slot_status;

    typedef struct packed {
        logic [DEG_W-1:0] deg;
        logic [RES_W-1:0] res;
    } t_entry;

    function automatic logic [POOL_W-1:0] pool_of(logic [MAP_W-1:0] map,
                                                  logic [SLOT_W-1:0] s);
        logic [POOL_W-1:0] p;
        p = '0;
        if (int'(s) < MAP_SLOTS) p = map[POOL_W*s +: POOL_W];
        return p;
    endfunction

    function automatic logic [NIDX_W-1:0] pool_size(logic [SIZES_W-1:0] sizes,
                                                    logic [POOL_W-1:0] p);
        logic [PSZ_W-1:0]  raw;
        logic [NIDX_W-1:0] n;
        raw = sizes[PSZ_W*p +: PSZ_W];
        if (int'(p) >= NUM_POOLS) n = '0;
        else if (int'(raw) > MAX_POOL_SIZE) n = NIDX_W'(MAX_POOL_SIZE);
        else n = NIDX_W'(raw);
        return n;
    endfunction

    function automatic logic [ADDR_W-1:0] tbl_addr(logic [POOL_W-1:0] p,
                                                   logic [IDX_W-1:0] m);
        return ADDR_W'(int'(p) * MAX_POOL_SIZE + int'(m));
    endfunction

endpackage

// File: hw/rtl/gce_table.sv
// member attribute memory: degree and resolution per pool member
// one write port, one registered read port; uses gce_pkg
module gce_table (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [gce_pkg::ADDR_W-1:0]  i_waddr,
    input  gce_pkg::t_entry             i_wdata,
    input  logic                        i_re,
    input  logic [gce_pkg::ADDR_W-1:0]  i_raddr,
    output gce_pkg::t_entry             o_rdata
);
    import gce_pkg::*;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/gce_slot_unit.sv
// slot index registers and the shared successor unit: one slot tried per cycle
// walks forward on a fit and backs up with carry on a miss; uses gce_pkg
`include "grouped_combination_enumerator_macros.svh"
module gce_slot_unit (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  gce_pkg::t_cfg                                     i_cfg,
    input  gce_pkg::t_slot_cmd                                i_cmd,
    output gce_pkg::t_slot_status                             o_status,
    output logic [gce_pkg::MAX_SLOTS-1:0][gce_pkg::IDX_W-1:0] o_idx
);
    import gce_pkg::*;

    logic [MAX_SLOTS-1:0]             r_valid;
    logic [MAX_SLOTS-1:0][IDX_W-1:0]  r_idx;
    logic [SLOT_W-1:0]                r_cur;

    logic [MAX_SLOTS-1:0][NIDX_W-1:0] plus1;
    logic [POOL_W-1:0]                cur_pool;
    logic [NIDX_W-1:0]                lo;
    logic [NIDX_W-1:0]                cand;
    logic [NIDX_W-1:0]                cur_size;
    logic [SLOT_W-1:0]                cur_nx;
    logic                             hit;
    logic                             last;
    logic                             all_unset;
    logic [MAX_SLOTS-1:0]             valid_try;

    // one past each stored index, zero for an unset slot
    always_comb begin
        for (int s = 0; s < MAX_SLOTS; s++) begin
            plus1[s] = r_valid[s] ? NIDX_W'(r_idx[s]) + NIDX_W'(1) : '0;
        end
    end

    // lowest index the cursor slot may take: above earlier slots of its pool
    always_comb begin
        cur_pool = pool_of(i_cfg.pool_map, r_cur);
        lo       = '0;
        for (int q = 0; q < MAX_SLOTS; q++) begin
            if (SLOT_W'(q) < r_cur && pool_of(i_cfg.pool_map, SLOT_W'(q)) == cur_pool
                    && plus1[q] > lo) begin
                lo = plus1[q];
            end
        end
        cand     = (plus1[r_cur] > lo) ? plus1[r_cur] : lo;
        cur_size = pool_size(i_cfg.pool_sizes, cur_pool);
        hit      = cand < cur_size;
        last     = (SCNT_W'(r_cur) + SCNT_W'(1)) == i_cfg.count;
        cur_nx   = r_cur + SLOT_W'(1);
    end

    // valid bits after one try
    always_comb begin
        valid_try = r_valid;
        if (hit) begin
            valid_try[r_cur] = 1'b1;
            // entering the next slot starts it from its lowest index
            if (!last) valid_try[cur_nx] = 1'b0;
        end else begin
            valid_try[r_cur] = 1'b0;
        end
    end

    always_comb begin
        o_status.restart_ok = i_cfg.count != '0;
        o_status.any_unset  = 1'b0;
        all_unset           = 1'b1;
        for (int s = 0; s < MAX_SLOTS; s++) begin
            if (SCNT_W'(s) < i_cfg.count) begin
                if (pool_size(i_cfg.pool_sizes, pool_of(i_cfg.pool_map, SLOT_W'(s))) == '0) begin
                    o_status.restart_ok = 1'b0;
                end
                if (!r_valid[s]) o_status.any_unset = 1'b1;
                else all_unset = 1'b0;
            end
        end
        o_status.success = (i_cmd == SC_TRY) && hit && last;
        o_status.fail    = (i_cmd == SC_TRY) && !hit && (r_cur == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_cur   <= '0;
        end else begin
            unique case (i_cmd)
                SC_CLEAR: begin
                    r_valid <= '0;
                    r_cur   <= '0;
                end
                SC_START_STEP: begin
                    r_cur <= SLOT_W'(i_cfg.count - SCNT_W'(1));
                end
                SC_TRY: begin
                    r_valid <= valid_try;
                    if (hit) begin
                        if (!last) r_cur <= cur_nx;
                    end else begin
                        // carry to the left
                        if (r_cur != '0) r_cur <= r_cur - SLOT_W'(1);
                    end
                end
                SC_IDLE: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == SC_TRY && hit) begin
            r_idx[r_cur] <= cand[IDX_W-1:0];
        end
    end

    assign o_idx = r_idx;

    `GCE_ASSERT_NEXT(a_success_all_set, o_status.success, !o_status.any_unset, "slot unset after success")
    `GCE_ASSERT_NEXT(a_fail_all_unset, o_status.fail, all_unset, "slot left set after exhaustion")
    `GCE_ASSERT_SAME(a_cur_in_range, i_cmd == SC_TRY, SCNT_W'(r_cur) < i_cfg.count, "cursor beyond slot count")

endmodule

// File: hw/rtl/grouped_combination_enumerator.sv
// Load beat: written to the table at the accepting edge, no result, ready stays high.
// Restart beat (or advance on an unset slot): restart check, slot tries in search, then a table
// read and an accumulate step per used slot, then deliver; an advance beat skips the restart
// check. Slot tries run one per cycle; an exhausted result walks no slots in the table.
// Next beat accepted in the cycle after the result loads; a held result stalls in deliver.
// Synchronous active-low reset: control and config registers to reset values, slots unset, done clear, no table clear.
`include "grouped_combination_enumerator_macros.svh"
module grouped_combination_enumerator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gce_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [gce_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [gce_pkg::OP_W-1:0]          i_operation,
    input  logic [gce_pkg::POOL_W-1:0]        i_load_pool,
    input  logic [gce_pkg::MEMBER_W-1:0]      i_load_member,
    input  logic [gce_pkg::DEG_W-1:0]         i_member_degree,
    input  logic [gce_pkg::RES_W-1:0]         i_member_resolution,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_found,
    output logic [gce_pkg::SEL_W-1:0]         o_selection,
    output logic [gce_pkg::TOT_W-1:0]         o_total_degree,
    output logic [gce_pkg::RES_W-1:0]         o_min_resolution
);
    import gce_pkg::*;

    logic [CNT_CFG_W-1:0] r_slot_count;
    logic [MAP_W-1:0]     r_pool_map;
    logic [SIZES_W-1:0]   r_pool_sizes;
    logic [RES_W-1:0]     r_lmax;

    t_state            r_state, n_state;
    logic              r_done, n_done;
    logic              r_found, n_found;
    logic [SLOT_W-1:0] r_emit, n_emit;
    logic [SEL_W-1:0]  r_sel, n_sel;
    logic [TOT_W-1:0]  r_deg, n_deg;
    logic [RES_W-1:0]  r_min, n_min;

    logic              r_out_valid;
    logic              r_o_found;
    logic [SEL_W-1:0]  r_o_sel;
    logic [TOT_W-1:0]  r_o_deg;
    logic [RES_W-1:0]  r_o_min;

    t_cfg                            cfg;
    t_slot_cmd                       cmd;
    t_slot_status                    st;
    logic [MAX_SLOTS-1:0][IDX_W-1:0] idx;
    logic                            in_acc;
    logic                            out_load;
    logic                            tbl_we;
    logic                            tbl_re;
    logic [ADDR_W-1:0]               tbl_raddr;
    t_entry                          wr_entry;
    t_entry                          rd_entry;
    logic                            emit_last;

    always_comb begin
        cfg.count      = (int'(r_slot_count) > MAX_SLOTS) ? SCNT_W'(MAX_SLOTS)
                                                          : SCNT_W'(r_slot_count);
        cfg.pool_map   = r_pool_map;
        cfg.pool_sizes = r_pool_sizes;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= '0;
            r_pool_map   <= '0;
            r_pool_sizes <= '0;
            r_lmax       <= LMAX_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SLOT_COUNT: r_slot_count <= i_cfg_data[CNT_CFG_W-1:0];
                CFG_POOL_MAP:   r_pool_map   <= i_cfg_data[MAP_W-1:0];
                CFG_POOL_SIZES: r_pool_sizes <= i_cfg_data[SIZES_W-1:0];
                CFG_LMAX:       r_lmax       <= i_cfg_data[RES_W-1:0];
            endcase
        end
    end

    gce_slot_unit u_slots (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_cmd    (cmd),
        .o_status (st),
        .o_idx    (idx)
    );

    assign wr_entry.deg = i_member_degree;
    assign wr_entry.res = i_member_resolution;

    gce_table u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_addr(i_load_pool, i_load_member)),
        .i_wdata (wr_entry),
        .i_re    (tbl_re),
        .i_raddr (tbl_raddr),
        .o_rdata (rd_entry)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign emit_last  = (SCNT_W'(r_emit) + SCNT_W'(1)) == cfg.count;
    assign tbl_raddr  = tbl_addr(pool_of(r_pool_map, r_emit), idx[r_emit]);

    always_comb begin
        n_state  = r_state;
        n_done   = r_done;
        n_found  = r_found;
        n_emit   = r_emit;
        n_sel    = r_sel;
        n_deg    = r_deg;
        n_min    = r_min;
        cmd      = SC_IDLE;
        tbl_we   = 1'b0;
        tbl_re   = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (t_op'(i_operation))
                        OP_LOAD: begin
                            tbl_we = int'(i_load_pool) < NUM_POOLS
                                  && int'(i_load_member) < MAX_POOL_SIZE;
                        end
                        OP_RESTART: n_state = ST_RESTART;
                        OP_ADVANCE: begin
                            priority if (r_done) begin
                                n_found = 1'b0;
                                n_state = ST_DELIVER;
                            end else if (st.any_unset) begin
                                n_state = ST_RESTART;
                            end else if (cfg.count == '0) begin
                                n_done  = 1'b1;
                                n_found = 1'b0;
                                n_state = ST_DELIVER;
                            end else begin
                                cmd     = SC_START_STEP;
                                n_state = ST_SEARCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RESTART: begin
                if (!st.restart_ok) begin
                    // slot indices stay as they were
                    n_done  = 1'b1;
                    n_found = 1'b0;
                    n_state = ST_DELIVER;
                end else begin
                    cmd     = SC_CLEAR;
                    n_done  = 1'b0;
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                cmd = SC_TRY;
                priority if (st.success) begin
                    n_found = 1'b1;
                    n_emit  = '0;
                    n_sel   = '0;
                    n_deg   = '0;
                    n_min   = '1;
                    n_state = ST_EMIT_RD;
                end else if (st.fail) begin
                    n_done  = 1'b1;
                    n_found = 1'b0;
                    n_state = ST_DELIVER;
                end else begin
                end
            end
            ST_EMIT_RD: begin
                tbl_re  = 1'b1;
                n_state = ST_EMIT_ACC;
            end
            ST_EMIT_ACC: begin
                if (int'(r_emit) < MAP_SLOTS) n_sel[IDX_W*r_emit +: IDX_W] = idx[r_emit];
                n_deg = r_deg + TOT_W'(rd_entry.deg);
                if (rd_entry.res < r_min) n_min = rd_entry.res;
                if (emit_last) begin
                    n_state = ST_DELIVER;
                end else begin
                    n_emit  = r_emit + SLOT_W'(1);
                    n_state = ST_EMIT_RD;
                end
            end
            ST_DELIVER: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_done      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_found <= n_found;
            if (out_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_emit <= n_emit;
        r_sel  <= n_sel;
        r_deg  <= n_deg;
        r_min  <= n_min;
        if (out_load) begin
            // exhausted beat carries zeros
            r_o_found <= r_found;
            r_o_sel   <= r_found ? r_sel : '0;
            r_o_deg   <= r_found ? r_deg : '0;
            r_o_min   <= !r_found ? '0 : (r_min > r_lmax) ? r_lmax : r_min;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_found          = r_o_found;
    assign o_selection      = r_o_sel;
    assign o_total_degree   = r_o_deg;
    assign o_min_resolution = r_o_min;

    `GCE_ASSERT_NEXT(a_done_advance, in_acc && i_operation == OP_ADVANCE && r_done, r_state == ST_DELIVER, "advance after exhaustion did not answer at once")
    `GCE_ASSERT_SAME(a_min_capped, o_out_valid && o_found, o_min_resolution <= r_lmax, "min resolution above cap")
    `GCE_ASSERT_SAME(a_none_zero, o_out_valid && !o_found, o_selection == '0 && o_total_degree == '0 && o_min_resolution == '0, "exhausted beat carries data")

endmodule

// File: bench/grouped_combination_enumerator_tb.sv
`timescale 1ns / 1ps
// self-checking bench for grouped_combination_enumerator: directed table, then random phases
// predicts every selection in-line from its own copy of registers, slot indices and member table
// depends on gce_pkg and the grouped_combination_enumerator rtl only
module tb;
    import gce_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 20000;
    localparam int PHASES        = 8;
    localparam int PHASE_BEATS   = 225;

    typedef struct packed {
        logic             found;
        logic [SEL_W-1:0] sel;
        logic [TOT_W-1:0] total;
        logic [RES_W-1:0] minres;
    } t_outcome;

    typedef struct {
        bit                    is_reg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [OP_W-1:0]       op;
        logic [POOL_W-1:0]     pool;
        logic [MEMBER_W-1:0]   member;
        logic [DEG_W-1:0]      deg;
        logic [RES_W-1:0]      res;
        bit                    fixed;
        t_outcome              want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [OP_W-1:0]       i_operation = '0;
    logic [POOL_W-1:0]     i_load_pool = '0;
    logic [MEMBER_W-1:0]   i_load_member = '0;
    logic [DEG_W-1:0]      i_member_degree = '0;
    logic [RES_W-1:0]      i_member_resolution = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_found;
    logic [SEL_W-1:0]      o_selection;
    logic [TOT_W-1:0]      o_total_degree;
    logic [RES_W-1:0]      o_min_resolution;

    grouped_combination_enumerator dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_operation        (i_operation),
        .i_load_pool        (i_load_pool),
        .i_load_member      (i_load_member),
        .i_member_degree    (i_member_degree),
        .i_member_resolution(i_member_resolution),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_found            (o_found),
        .o_selection        (o_selection),
        .o_total_degree     (o_total_degree),
        .o_min_resolution   (o_min_resolution)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // predictor state
    logic [CNT_CFG_W-1:0] cfg_count;
    logic [MAP_W-1:0]     cfg_map;
    logic [SIZES_W-1:0]   cfg_sizes;
    logic [RES_W-1:0]     cfg_lmax;
    int                   slot_pos [MAX_SLOTS];
    bit                   enum_done;
    logic [DEG_W-1:0]     degree_mem [TABLE_DEPTH];
    logic [RES_W-1:0]     resol_mem [TABLE_DEPTH];

    t_outcome pending_outcomes[$];
    int       mismatches = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       hold_requests = 0;
    int       holds_taken = 0;
    int       hold_left = 0;
    int       quiet_cycles = 0;

    function automatic int slots_in_use();
        return (int'(cfg_count) > MAX_SLOTS) ? MAX_SLOTS : int'(cfg_count);
    endfunction

    function automatic int pool_at(int s);
        return int'(cfg_map[2*s +: 2]);
    endfunction

    function automatic int members_at(int s);
        int n;
        n = int'(cfg_sizes[5*pool_at(s) +: 5]);
        return (n > MAX_POOL_SIZE) ? MAX_POOL_SIZE : n;
    endfunction

    // slots sharing a pool must stay strictly increasing
    function automatic int first_free(int s);
        int lo;
        lo = 0;
        for (int q = 0; q < s; q++)
            if (pool_at(q) == pool_at(s) && slot_pos[q] + 1 > lo) lo = slot_pos[q] + 1;
        return lo;
    endfunction

    function automatic bit fill_slots(int s, int cnt);
        int n;
        if (s >= cnt) return 1'b1;
        n = members_at(s);
        for (int i = first_free(s); i < n; i++) begin
            slot_pos[s] = i;
            if (fill_slots(s + 1, cnt)) return 1'b1;
        end
        slot_pos[s] = -1;
        return 1'b0;
    endfunction

    // odometer step, carry toward slot 0
    function automatic bit step_slots(int s, int cnt);
        int n, lo, i;
        while (s >= 0) begin
            n = members_at(s);
            lo = first_free(s);
            i = (slot_pos[s] + 1 > lo) ? slot_pos[s] + 1 : lo;
            while (i < n) begin
                slot_pos[s] = i;
                if (fill_slots(s + 1, cnt)) return 1'b1;
                i++;
            end
            slot_pos[s] = -1;
            s--;
        end
        return 1'b0;
    endfunction

    function automatic t_outcome selection_of(int cnt);
        t_outcome r;
        int       m, addr, lowest;
        r = '0;
        lowest = 1 << 30;
        for (int s = 0; s < cnt; s++) begin
            m = slot_pos[s] & 15;
            addr = pool_at(s) * MAX_POOL_SIZE + m;
            r.sel[4*s +: 4] = 4'(m);
            r.total = r.total + TOT_W'(degree_mem[addr]);
            if (int'(resol_mem[addr]) < lowest) lowest = int'(resol_mem[addr]);
        end
        if (lowest > int'(cfg_lmax)) lowest = int'(cfg_lmax);
        r.found = 1'b1;
        r.minres = RES_W'(lowest);
        return r;
    endfunction

    function automatic t_outcome restart_enum();
        int cnt;
        cnt = slots_in_use();
        if (cnt == 0) begin
            enum_done = 1'b1;
            return '0;
        end
        // an empty pool fails the check but leaves the indices alone
        for (int s = 0; s < cnt; s++)
            if (members_at(s) == 0) begin
                enum_done = 1'b1;
                return '0;
            end
        for (int s = 0; s < MAX_SLOTS; s++) slot_pos[s] = -1;
        enum_done = 1'b0;
        if (!fill_slots(0, cnt)) begin
            enum_done = 1'b1;
            return '0;
        end
        return selection_of(cnt);
    endfunction

    function automatic bit next_outcome(input logic [OP_W-1:0] op,
                                        input logic [POOL_W-1:0] pool,
                                        input logic [MEMBER_W-1:0] member,
                                        input logic [DEG_W-1:0] deg,
                                        input logic [RES_W-1:0] res,
                                        output t_outcome r);
        int cnt;
        r = '0;
        case (op)
            OP_LOAD: begin
                degree_mem[int'(pool) * MAX_POOL_SIZE + int'(member)] = deg;
                resol_mem[int'(pool) * MAX_POOL_SIZE + int'(member)] = res;
                return 1'b0;
            end
            OP_RESTART: begin
                r = restart_enum();
                return 1'b1;
            end
            OP_ADVANCE: begin
                if (enum_done) return 1'b1;
                cnt = slots_in_use();
                // an unset slot in use turns the advance into a restart
                for (int s = 0; s < cnt; s++)
                    if (slot_pos[s] < 0) begin
                        r = restart_enum();
                        return 1'b1;
                    end
                if (cnt == 0 || !step_slots(cnt - 1, cnt)) enum_done = 1'b1;
                else r = selection_of(cnt);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic send_beat(input logic [OP_W-1:0] op, input logic [POOL_W-1:0] pool,
                             input logic [MEMBER_W-1:0] member, input logic [DEG_W-1:0] deg,
                             input logic [RES_W-1:0] res, input bit fixed,
                             input t_outcome want);
        t_outcome predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_operation         <= op;
        i_load_pool         <= pool;
        i_load_member       <= member;
        i_member_degree     <= deg;
        i_member_resolution <= res;
        do @(posedge i_clk); while (!o_in_ready);
        if (next_outcome(op, pool, member, deg, res, predicted))
            pending_outcomes = {pending_outcomes, (fixed ? want : predicted)};
    endtask

    // drain, then give a trailing load or unused op time to finish
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SLOT_COUNT: cfg_count = val[CNT_CFG_W-1:0];
            CFG_POOL_MAP:   cfg_map   = val[MAP_W-1:0];
            CFG_POOL_SIZES: cfg_sizes = val[SIZES_W-1:0];
            CFG_LMAX:       cfg_lmax  = val[RES_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic t_row reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        t_row r;
        r = '{default: '0};
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic t_row op_row(logic [OP_W-1:0] op, bit exhausted);
        t_row r;
        r = '{default: '0};
        r.op    = op;
        r.deg   = DEG_W'($urandom);
        r.fixed = exhausted;
        return r;
    endfunction

    function automatic t_row load_row(logic [POOL_W-1:0] pool, logic [MEMBER_W-1:0] member,
                                      logic [DEG_W-1:0] deg, logic [RES_W-1:0] res);
        t_row r;
        r = '{default: '0};
        r.op     = OP_LOAD;
        r.pool   = pool;
        r.member = member;
        r.deg    = deg;
        r.res    = res;
        return r;
    endfunction

    // result side: check each beat against the oldest expectation, stall at random
    always @(posedge i_clk) begin
        t_outcome got, want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_found, o_selection, o_total_degree, o_min_resolution};
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: found=%0d sel=%h total=%0d minres=%0d",
                             got.found, got.sel, got.total, got.minres);
            end else begin
                want = pending_outcomes.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d %h %0d %0d, got %0d %h %0d %0d",
                                 want.found, want.sel, want.total, want.minres,
                                 got.found, got.sel, got.total, got.minres);
                end
            end
        end
        if (hold_requests != holds_taken) begin
            holds_taken <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_row               script[$];
        t_row               row;
        logic [SIZES_W-1:0] sizes;
        logic [OP_W-1:0]    op;
        logic [RES_W-1:0]   res;
        int                 pick;

        cfg_count = '0;
        cfg_map   = '0;
        cfg_sizes = '0;
        cfg_lmax  = LMAX_RST;
        for (int s = 0; s < MAX_SLOTS; s++) slot_pos[s] = -1;
        enum_done = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // write every table entry before anything reads it
        for (int p = 0; p < NUM_POOLS; p++)
            for (int m = 0; m < MAX_POOL_SIZE; m++)
                send_beat(OP_LOAD, POOL_W'(p), MEMBER_W'(m),
                          (m == 0) ? '0 : (m == 15) ? '1 : DEG_W'($urandom),
                          RES_W'($urandom_range(64, 1)), 1'b0, '0);

        // no slots: always exhausted, and op 3 does nothing
        script = {script, reg_row(CFG_SLOT_COUNT, 0)};
        script = {script, op_row(OP_RESTART, 1'b1)};
        script = {script, op_row(OP_ADVANCE, 1'b1)};
        script = {script, op_row(OP_UNUSED, 1'b0)};
        script = {script, load_row(3, 15, 16'hFFFF, 7'd64)};
        script = {script, load_row(0, 0, 16'h0000, 7'd1)};
        script = {script, load_row(0, 1, 16'hFFFF, 7'd127)};
        script = {script, load_row(2, 7, 16'h5A5A, 7'd0)};
        // two slots on one pool of three: (0,1) (0,2) (1,2) then exhausted
        script = {script, reg_row(CFG_SLOT_COUNT, 2)};
        script = {script, reg_row(CFG_POOL_MAP, 'h00)};
        script = {script, reg_row(CFG_POOL_SIZES, 3)};
        script = {script, reg_row(CFG_LMAX, 64)};
        script = {script, op_row(OP_RESTART, 1'b0)};
        script = {script, op_row(OP_ADVANCE, 1'b0)};
        script = {script, op_row(OP_ADVANCE, 1'b0)};
        script = {script, op_row(OP_ADVANCE, 1'b1)};
        script = {script, op_row(OP_ADVANCE, 1'b1)};
        // slot count and pool sizes saturate
        script = {script, reg_row(CFG_SLOT_COUNT, 7)};
        script = {script, reg_row(CFG_POOL_MAP, 'hFF)};
        script = {script, reg_row(CFG_POOL_SIZES, 20'hFFFFF)};
        script = {script, reg_row(CFG_LMAX, 1)};
        script = {script, op_row(OP_RESTART, 1'b0)};
        script = {script, op_row(OP_ADVANCE, 1'b0)};
        script = {script, reg_row(CFG_LMAX, 0)};
        script = {script, op_row(OP_ADVANCE, 1'b0)};
        script = {script, reg_row(CFG_LMAX, 127)};
        script = {script, op_row(OP_ADVANCE, 1'b0)};
        // empty pool fails the restart, the advance after it sees done
        script = {script, reg_row(CFG_POOL_SIZES, 0)};
        script = {script, op_row(OP_RESTART, 1'b1)};
        script = {script, reg_row(CFG_POOL_SIZES, 20'hFFFFF)};
        script = {script, reg_row(CFG_SLOT_COUNT, 1)};
        script = {script, op_row(OP_ADVANCE, 1'b1)};
        script = {script, op_row(OP_RESTART, 1'b0)};
        // grown slot count leaves unset slots, then pools shrink under live indices
        script = {script, reg_row(CFG_SLOT_COUNT, 3)};
        script = {script, reg_row(CFG_POOL_MAP, 'h1B)};
        script = {script, op_row(OP_ADVANCE, 1'b0)};
        script = {script, op_row(OP_ADVANCE, 1'b0)};
        script = {script, reg_row(CFG_POOL_SIZES, 20'(4 | (2 << 5) | (1 << 10) | (16 << 15)))};
        script = {script, op_row(OP_ADVANCE, 1'b0)};
        script = {script, op_row(OP_ADVANCE, 1'b0)};
        script = {script, op_row(OP_ADVANCE, 1'b0)};

        foreach (script[i]) begin
            row = script[i];
            if (row.is_reg) begin
                settle();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                send_beat(row.op, row.pool, row.member, row.deg, row.res, row.fixed, row.want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            if (ph == 0) begin
                // one deep run: four slots choosing from a single pool of sixteen
                write_reg(CFG_SLOT_COUNT, 4);
                write_reg(CFG_POOL_MAP, 'h00);
                write_reg(CFG_POOL_SIZES, 20'(16 | (16 << 5) | (16 << 10) | (16 << 15)));
                write_reg(CFG_LMAX, 64);
            end else begin
                pick = $urandom_range(9);
                write_reg(CFG_SLOT_COUNT, CFG_DATA_W'((pick == 0) ? 0 :
                                                     (pick == 1) ? $urandom_range(7, 5) :
                                                                   $urandom_range(4, 1)));
                write_reg(CFG_POOL_MAP, CFG_DATA_W'($urandom_range(255)));
                for (int p = 0; p < NUM_POOLS; p++) begin
                    pick = $urandom_range(19);
                    sizes[PSZ_W*p +: PSZ_W] = (pick == 0) ? '0 :
                                              (pick == 1) ? PSZ_W'($urandom_range(31, 16)) :
                                                            PSZ_W'($urandom_range(8, 1));
                end
                write_reg(CFG_POOL_SIZES, sizes);
                write_reg(CFG_LMAX, CFG_DATA_W'(($urandom_range(9) == 0) ?
                                                $urandom_range(127) : $urandom_range(64, 1)));
            end
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            // long hold on the result side while beats keep coming
            if (ph == 4) hold_requests++;
            for (int k = 0; k < PHASE_BEATS; k++) begin
                pick = $urandom_range(99);
                op = (pick < 2) ? OP_UNUSED : (pick < 8) ? OP_LOAD :
                     (pick < 18) ? OP_RESTART : OP_ADVANCE;
                res = ($urandom_range(9) == 0) ? RES_W'($urandom_range(127)) :
                                                 RES_W'($urandom_range(64, 1));
                send_beat(op, POOL_W'($urandom), MEMBER_W'($urandom), DEG_W'($urandom),
                          res, 1'b0, '0);
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
